// ----- hdl/indexed_list_engine_top_macros.svh -----
// assertion macros for the indexed list engine checker
// expects clk and rst_n in the scope where a macro is used
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define ILE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ile_pkg.sv -----
// shared types and codes for the indexed list engine
// no dependencies
package ile_pkg;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam logic [OPCODE_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_OVERWRITE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_READ      = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DELETE    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                load;
    logic                wr_tail;
    logic                wr_pos;
    logic                rd_pos;
    logic                rd_shift;
    logic                wr_shift;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                take_read;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                out_load;
  } ile_cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                in_range;
    logic                full;
    logic                shift_more;
    logic                out_free;
  } ile_stat_t;

endpackage

// ----- hdl/indexed_list_engine_top.sv -----
// an input beat goes from idle through exec to finish, which registers the
// result once the output is free; read adds a read state, insert and delete a
// shift-read and a shift-write state per moved entry (one read and one write
// of element memory each); a new beat is taken once the result is registered
// rst_n (synchronous) empties the list; element memory is not cleared
module indexed_list_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ile_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [ile_pkg::POS_W-1:0]          in_position,
  input  logic signed [ile_pkg::VALUE_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ile_pkg::VALUE_W-1:0] out_read_value,
  output logic [ile_pkg::STATUS_W-1:0]       out_status,
  output logic [ile_pkg::LEN_W-1:0]          out_list_length
);
  import ile_pkg::*;

  ile_cmd_t  cmd;
  ile_stat_t stat;

  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ile_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_list_length (out_list_length),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// ----- hdl/ile_ctrl.sv -----
// control state machine for the indexed list engine
// depends on ile_pkg; drives the datapath through ile_cmd_t
module ile_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ile_pkg::ile_stat_t stat,
  output ile_pkg::ile_cmd_t  cmd
);
  import ile_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_SHIFT_RD = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FINISH;
        unique case (stat.op)
          OP_APPEND: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.wr_tail = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end
          OP_INSERT: begin
            if (!stat.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              state_nxt = S_SHIFT_RD;
            end
          end
          OP_OVERWRITE: begin
            if (!stat.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.wr_pos = 1'b1;
            end
          end
          OP_READ: begin
            if (!stat.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.rd_pos = 1'b1;
              state_nxt  = S_READ;
            end
          end
          OP_DELETE: begin
            if (!stat.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              state_nxt = S_SHIFT_RD;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.rd_shift = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end else begin
          if (stat.op == OP_INSERT) begin
            cmd.wr_pos  = 1'b1;
            cmd.cnt_inc = 1'b1;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
          state_nxt = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_READ: begin
        cmd.take_read = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/ile_datapath.sv -----
// element memory, length counter, shift index and result registers
// depends on ile_pkg; controlled by ile_ctrl through ile_cmd_t
module ile_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [ile_pkg::OPCODE_W-1:0]          in_opcode,
  input  logic [ile_pkg::POS_W-1:0]             in_position,
  input  logic signed [ile_pkg::VALUE_W-1:0]    in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ile_pkg::VALUE_W-1:0]    out_read_value,
  output logic [ile_pkg::STATUS_W-1:0]          out_status,
  output logic [ile_pkg::LEN_W-1:0]             out_list_length,
  input  ile_pkg::ile_cmd_t                     cmd,
  output ile_pkg::ile_stat_t                    stat
);
  import ile_pkg::*;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic signed [VALUE_W-1:0] store_r [CAPACITY];

  logic [CNT_W-1:0]          count_r,  count_nxt;
  logic [ADDR_W-1:0]         idx_r,    idx_nxt;
  logic [OPCODE_W-1:0]       op_r,     op_nxt;
  logic [POS_W-1:0]          pos_r,    pos_nxt;
  logic signed [VALUE_W-1:0] val_r,    val_nxt;
  logic signed [VALUE_W-1:0] rd_data_r;
  logic signed [VALUE_W-1:0] res_rdval_r, res_rdval_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_read_value_r, out_read_value_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [LEN_W-1:0]          out_list_length_r, out_list_length_nxt;

  logic [WIDE_W-1:0] count_w, pos_w, idx_w, idx_inc_w, pos_in_w, cap_w;
  logic [ADDR_W-1:0] pos_a, tail_a, shift_a, idx_step;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic signed [VALUE_W-1:0] wr_data;

  assign count_w   = WIDE_W'(count_r);
  assign pos_w     = WIDE_W'(pos_r);
  assign idx_w     = WIDE_W'(idx_r);
  assign idx_inc_w = idx_w + WIDE_W'(1);
  assign pos_in_w  = WIDE_W'(in_position);
  assign cap_w     = WIDE_W'(CAPACITY);

  assign pos_a    = pos_w[ADDR_W-1:0];
  assign tail_a   = count_w[ADDR_W-1:0];
  assign idx_step = (op_r == OP_INSERT) ? (idx_r - ADDR_W'(1)) : (idx_r + ADDR_W'(1));
  assign shift_a  = idx_step;

  assign stat.op         = op_r;
  assign stat.in_range   = (pos_w < count_w) && (pos_w < cap_w);
  assign stat.full       = (count_w >= cap_w);
  assign stat.shift_more = (op_r == OP_INSERT) ? (idx_w > pos_w) : (idx_inc_w < count_w);
  assign stat.out_free   = !out_valid_r || out_ready;

  // memory port selection
  assign rd_en   = cmd.rd_pos || cmd.rd_shift;
  assign rd_addr = cmd.rd_pos ? pos_a : shift_a;
  assign wr_en   = cmd.wr_tail || cmd.wr_pos || cmd.wr_shift;

  always_comb begin
    wr_addr = idx_r;
    wr_data = rd_data_r;
    if (cmd.wr_tail) begin
      wr_addr = tail_a;
      wr_data = val_r;
    end else if (cmd.wr_pos) begin
      wr_addr = pos_a;
      wr_data = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  always_comb begin
    count_nxt           = count_r;
    idx_nxt             = idx_r;
    op_nxt              = op_r;
    pos_nxt             = pos_r;
    val_nxt             = val_r;
    res_rdval_nxt       = res_rdval_r;
    res_status_nxt      = res_status_r;
    out_valid_nxt       = out_valid_r;
    out_read_value_nxt  = out_read_value_r;
    out_status_nxt      = out_status_r;
    out_list_length_nxt = out_list_length_r;

    if (cmd.load) begin
      op_nxt         = in_opcode;
      pos_nxt        = in_position;
      val_nxt        = in_value;
      idx_nxt        = (in_opcode == OP_INSERT) ? count_w[ADDR_W-1:0] : pos_in_w[ADDR_W-1:0];
      res_rdval_nxt  = '0;
      res_status_nxt = ST_DONE;
    end
    if (cmd.wr_shift) begin
      idx_nxt = idx_step;
    end
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.set_status) begin
      res_status_nxt = cmd.status;
    end
    if (cmd.take_read) begin
      res_rdval_nxt = rd_data_r;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt       = 1'b1;
      out_read_value_nxt  = res_rdval_r;
      out_status_nxt      = res_status_r;
      out_list_length_nxt = count_w[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r             <= idx_nxt;
    op_r              <= op_nxt;
    pos_r             <= pos_nxt;
    val_r             <= val_nxt;
    res_rdval_r       <= res_rdval_nxt;
    res_status_r      <= res_status_nxt;
    out_read_value_r  <= out_read_value_nxt;
    out_status_r      <= out_status_nxt;
    out_list_length_r <= out_list_length_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_status      = out_status_r;
  assign out_list_length = out_list_length_r;

endmodule

// ----- hdl/ile_checker.sv -----
// port-level checks for indexed_list_engine_top, bound to the top level
// depends on ile_pkg and indexed_list_engine_top_macros.svh
`include "indexed_list_engine_top_macros.svh"

module ile_checker #(
  parameter int CAPACITY = 64
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ile_pkg::VALUE_W-1:0] out_read_value,
  input logic [ile_pkg::STATUS_W-1:0]       out_status,
  input logic [ile_pkg::LEN_W-1:0]          out_list_length
);
  import ile_pkg::*;

  // stalled result beat holds
  `ILE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_list_length), "stalled result beat changed")

  // one beat in flight
  `ILE_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input taken while busy")

  // rejected operations read back zero
  `ILE_ASSERT_IMP(a_reject_zero, out_valid && (out_status != ST_DONE), out_read_value == 0, "nonzero read value on rejected beat")

  // full status only at capacity
  `ILE_ASSERT_IMP(a_full_len, out_valid && (out_status == ST_FULL), out_list_length == LEN_W'(CAPACITY), "full status below capacity")

endmodule

bind indexed_list_engine_top ile_checker #(
  .CAPACITY (CAPACITY)
) u_ile_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_list_length (out_list_length)
);
